@@ hdl/mbph_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbph_pkg
// Shared constants and types for the level meter ballistics and peak hold.
// ----------------------------------------------------------------------------
package mbph_pkg;

  // default datapath sizes
  localparam int LEVEL_WIDTH         = 24;
  localparam int COEFF_FRACTION_BITS = 16;
  localparam int HOLD_WIDTH          = 16;

  // configuration port
  localparam int PADDR_WIDTH = 4;
  localparam int PDATA_WIDTH = 32;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_RELEASE = 2'd1,
    REG_FALL    = 2'd2,
    REG_HOLD    = 2'd3
  } reg_idx_t;

  // register reset values, cut to the coefficient width where used
  localparam logic [31:0]           RELEASE_RESET = 32'd3277;
  localparam logic [31:0]           FALL_RESET    = 32'd64880;
  localparam logic [HOLD_WIDTH-1:0] HOLD_RESET    = 16'd30;

endpackage
`default_nettype wire

@@ hdl/mbph_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbph channel interfaces
// Valid/ready channels for target levels in and meter results out.
// ----------------------------------------------------------------------------
interface mbph_in_if #(
  parameter int LEVEL_WIDTH = mbph_pkg::LEVEL_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [LEVEL_WIDTH-1:0] target_level;

  modport source (output valid, output target_level, input ready);
  modport sink   (input valid, input target_level, output ready);
endinterface

interface mbph_out_if #(
  parameter int LEVEL_WIDTH = mbph_pkg::LEVEL_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic [LEVEL_WIDTH-2:0] smoothed_level;
  logic [LEVEL_WIDTH-2:0] peak_level;
  logic                   holding;

  modport source (output valid, output smoothed_level, output peak_level, output holding,
                  input ready);
  modport sink   (input valid, input smoothed_level, input peak_level, input holding,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/mbph_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbph_regs
// APB register file holding the ballistics coefficients and hold length.
// ----------------------------------------------------------------------------
module mbph_regs #(
  parameter int COEFF_FRACTION_BITS = mbph_pkg::COEFF_FRACTION_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mbph_pkg::PADDR_WIDTH-1:0]    paddr,
  input  logic [mbph_pkg::PDATA_WIDTH-1:0]    pwdata,
  output logic [mbph_pkg::PDATA_WIDTH-1:0]    prdata,
  output logic                                pready,
  output logic [COEFF_FRACTION_BITS:0]        attack_coef,
  output logic [COEFF_FRACTION_BITS:0]        release_coef,
  output logic [COEFF_FRACTION_BITS:0]        fall_factor,
  output logic [mbph_pkg::HOLD_WIDTH-1:0]     hold_updates
);

  localparam int CW = COEFF_FRACTION_BITS + 1;
  localparam logic [CW-1:0] COEF_ONE = {1'b1, {COEFF_FRACTION_BITS{1'b0}}};

  mbph_pkg::reg_idx_t idx;
  logic               wr_en;

  // word address, byte offset ignored
  assign idx    = mbph_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_coef  <= COEF_ONE;
      release_coef <= mbph_pkg::RELEASE_RESET[CW-1:0];
      fall_factor  <= mbph_pkg::FALL_RESET[CW-1:0];
      hold_updates <= mbph_pkg::HOLD_RESET;
    end else if (wr_en) begin
      unique case (idx)
        mbph_pkg::REG_ATTACK:  attack_coef  <= pwdata[CW-1:0];
        mbph_pkg::REG_RELEASE: release_coef <= pwdata[CW-1:0];
        mbph_pkg::REG_FALL:    fall_factor  <= pwdata[CW-1:0];
        mbph_pkg::REG_HOLD:    hold_updates <= pwdata[mbph_pkg::HOLD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mbph_pkg::REG_ATTACK:  prdata = mbph_pkg::PDATA_WIDTH'(attack_coef);
      mbph_pkg::REG_RELEASE: prdata = mbph_pkg::PDATA_WIDTH'(release_coef);
      mbph_pkg::REG_FALL:    prdata = mbph_pkg::PDATA_WIDTH'(fall_factor);
      mbph_pkg::REG_HOLD:    prdata = mbph_pkg::PDATA_WIDTH'(hold_updates);
      default:               prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/meter_ballistics_peak_hold_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// a target enters the input register; its result is then registered in the state registers
// throughput: one target per cycle unless the result stalls; the smoother and the peak decay
// each use one multiplier in parallel between the input register and the level/peak/hold
// state registers; these double as the result register and hold while the result is stalled
// reset clears level, peak, hold and both valid flags, and loads the register defaults
// ----------------------------------------------------------------------------
// meter_ballistics_peak_hold_unit
// Attack/release level smoother with peak hold and exponential peak fall.
// ----------------------------------------------------------------------------
module meter_ballistics_peak_hold_unit #(
  parameter int LEVEL_WIDTH         = mbph_pkg::LEVEL_WIDTH,
  parameter int COEFF_FRACTION_BITS = mbph_pkg::COEFF_FRACTION_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  mbph_in_if.sink                          target_in,
  mbph_out_if.source                       result_out,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mbph_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [mbph_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic [mbph_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                             pready
);

  localparam int LW = LEVEL_WIDTH - 1;
  localparam int CW = COEFF_FRACTION_BITS + 1;
  localparam int PW = LW + CW;
  localparam int HW = mbph_pkg::HOLD_WIDTH;
  localparam logic [CW-1:0] COEF_ONE = {1'b1, {COEFF_FRACTION_BITS{1'b0}}};
  localparam logic [PW-1:0] ROUND_UP = PW'({COEFF_FRACTION_BITS{1'b1}});

  logic [CW-1:0] attack_coef;
  logic [CW-1:0] release_coef;
  logic [CW-1:0] fall_factor;
  logic [HW-1:0] hold_updates;

  mbph_regs #(
    .COEFF_FRACTION_BITS (COEFF_FRACTION_BITS)
  ) u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .attack_coef  (attack_coef),
    .release_coef (release_coef),
    .fall_factor  (fall_factor),
    .hold_updates (hold_updates)
  );

  // input register and handshake
  logic                          s1_valid;
  logic signed [LEVEL_WIDTH-1:0] s1_target;
  logic                          s1_adv;
  logic                          out_valid;

  assign s1_adv          = s1_valid && (!out_valid || result_out.ready);
  assign target_in.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (target_in.ready) begin
      s1_valid <= target_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (target_in.valid && target_in.ready) begin
      s1_target <= target_in.target_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // meter state
  logic [LW-1:0] level;
  logic [LW-1:0] peak;
  logic [HW-1:0] hold;
  logic [LW-1:0] level_next;
  logic [LW-1:0] peak_next;
  logic [HW-1:0] hold_next;

  logic [LW-1:0] target;
  logic          rising;
  logic          reach;
  logic [CW-1:0] coef_raw;
  logic [CW-1:0] coef;
  logic [CW-1:0] fall;
  logic [LW-1:0] diff;
  logic [PW-1:0] prod;
  logic [PW-1:0] prod_adj;
  logic [LW-1:0] step;
  logic [PW-1:0] decay_prod;
  logic [LW-1:0] decayed;

  always_comb begin
    // negative targets clamp to zero
    target   = s1_target[LEVEL_WIDTH-1] ? '0 : s1_target[LW-1:0];
    rising   = target > level;
    reach    = target >= level;
    coef_raw = rising ? attack_coef : release_coef;
    coef     = (coef_raw > COEF_ONE) ? COEF_ONE : coef_raw;
    fall     = (fall_factor > COEF_ONE) ? COEF_ONE : fall_factor;
    diff     = reach ? (target - level) : (level - target);
    prod     = PW'(coef) * PW'(diff);
    // falling step rounds up so the floored level never overshoots downward
    prod_adj = reach ? prod : (prod + ROUND_UP);
    step     = prod_adj[COEFF_FRACTION_BITS +: LW];

    if (reach) begin
      level_next = level + step;
    end else if (step > level) begin
      level_next = '0;
    end else begin
      level_next = level - step;
    end

    decay_prod = PW'(peak) * PW'(fall);
    decayed    = decay_prod[COEFF_FRACTION_BITS +: LW];

    peak_next = peak;
    hold_next = hold;
    if (level_next >= peak) begin
      peak_next = level_next;
      hold_next = hold_updates;
    end else if (hold != '0) begin
      hold_next = hold - HW'(1);
    end else begin
      peak_next = (decayed < level_next) ? level_next : decayed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      peak  <= '0;
      hold  <= '0;
    end else if (s1_adv) begin
      level <= level_next;
      peak  <= peak_next;
      hold  <= hold_next;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.smoothed_level = level;
  assign result_out.peak_level     = peak;
  assign result_out.holding        = (hold != '0);

`ifndef SYNTHESIS
  a_peak_not_below_level: assert property (@(posedge clk) disable iff (rst)
    peak >= level)
    else $error("peak fell below level");

  a_state_frozen: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(s1_adv)) |-> ($stable(level) && $stable(peak) && $stable(hold)))
    else $error("meter state changed without an update");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !result_out.ready) |-> !target_in.ready)
    else $error("input taken while a result is stalled and the input register is full");

  a_reload_on_peak: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && (level_next >= peak)) |=> ((peak == level) && (hold == hold_updates)))
    else $error("peak reached without hold reload");
`endif

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the level meter ballistics unit. Drives target levels
// through the input channel, programs the coefficients over the register
// port between phases, and checks every meter reading against a cycle-free
// model of the smoother, the peak hold and the peak fall.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LW = mbph_pkg::LEVEL_WIDTH;
  localparam int FB = mbph_pkg::COEFF_FRACTION_BITS;
  localparam int HW = mbph_pkg::HOLD_WIDTH;
  localparam int AW = mbph_pkg::PADDR_WIDTH;
  localparam int DW = mbph_pkg::PDATA_WIDTH;
  localparam logic [FB:0] COEF_ONE = (FB + 1)'(1) << FB;

  typedef struct packed {
    logic [LW-2:0] level;
    logic [LW-2:0] peak;
    logic          holding;
  } meter_reading_t;

  class meter_scoreboard;
    logic [FB:0]    attack_coef;
    logic [FB:0]    release_coef;
    logic [FB:0]    fall_coef;
    logic [HW-1:0]  hold_reload;
    logic [LW-2:0]  level;
    logic [LW-2:0]  peak;
    logic [HW-1:0]  hold_cnt;
    meter_reading_t expected_readings[$];
    int             failures;

    function new();
      attack_coef  = COEF_ONE;
      release_coef = (FB + 1)'(3277);
      fall_coef    = (FB + 1)'(64880);
      hold_reload  = HW'(30);
      level        = '0;
      peak         = '0;
      hold_cnt     = '0;
      failures     = 0;
    endfunction

    function logic [FB:0] unit_clamp(logic [FB:0] c);
      return (c > COEF_ONE) ? COEF_ONE : c;
    endfunction

    function void write_reg(mbph_pkg::reg_idx_t idx, logic [31:0] value);
      case (idx)
        mbph_pkg::REG_ATTACK:  attack_coef  = value[FB:0];
        mbph_pkg::REG_RELEASE: release_coef = value[FB:0];
        mbph_pkg::REG_FALL:    fall_coef    = value[FB:0];
        mbph_pkg::REG_HOLD:    hold_reload  = value[HW-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    // one meter update per accepted target
    function void note_target(logic signed [LW-1:0] t);
      logic [LW-2:0]  tgt;
      logic [FB:0]    coef;
      logic [63:0]    prod;
      logic [63:0]    down;
      meter_reading_t r;
      tgt  = t[LW-1] ? '0 : t[LW-2:0];
      coef = unit_clamp((tgt > level) ? attack_coef : release_coef);
      if (tgt >= level) begin
        prod  = 64'(coef) * 64'(tgt - level);
        level = level + (LW-1)'(prod >> FB);
      end else begin
        // falling step rounds up in magnitude, so the floor holds for the level
        prod  = 64'(coef) * 64'(level - tgt);
        down  = (prod + 64'(COEF_ONE) - 64'd1) >> FB;
        level = (down > 64'(level)) ? '0 : level - (LW-1)'(down);
      end
      if (level >= peak) begin
        peak     = level;
        hold_cnt = hold_reload;
      end else if (hold_cnt != 0) begin
        hold_cnt = hold_cnt - HW'(1);
      end else begin
        prod = 64'(peak) * 64'(unit_clamp(fall_coef));
        peak = (LW-1)'(prod >> FB);
        if (peak < level) peak = level;
      end
      r.level   = level;
      r.peak    = peak;
      r.holding = (hold_cnt != 0);
      expected_readings.push_back(r);
    endfunction

    function void check_reading(logic [LW-2:0] lvl, logic [LW-2:0] pk, logic hd);
      meter_reading_t want;
      if (expected_readings.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected reading: level=%0d peak=%0d holding=%0b", lvl, pk, hd);
        return;
      end
      want = expected_readings.pop_front();
      if (want.level !== lvl || want.peak !== pk || want.holding !== hd) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: level exp=%0d got=%0d peak exp=%0d got=%0d hold exp=%0b got=%0b",
                   want.level, lvl, want.peak, pk, want.holding, hd);
      end
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [AW-1:0] paddr;
  logic [DW-1:0] pwdata;
  logic [DW-1:0] prdata;
  logic          pready;
  int            src_idle_pct;
  int            sink_idle_pct;

  meter_scoreboard meter_sb = new();

  mbph_in_if  target_ch ();
  mbph_out_if result_ch ();

  meter_ballistics_peak_hold_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .target_in  (target_ch.sink),
    .result_out (result_ch.source),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // reading side: random back-pressure, check on every transfer
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready)
        meter_sb.check_reading(result_ch.smoothed_level, result_ch.peak_level,
                               result_ch.holding);
      result_ch.ready <= !rst && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_target(input logic signed [LW-1:0] t);
    while ($urandom_range(99) < src_idle_pct) begin
      target_ch.valid <= 1'b0;
      @(posedge clk);
    end
    target_ch.valid        <= 1'b1;
    target_ch.target_level <= t;
    do @(posedge clk); while (target_ch.ready !== 1'b1);
    meter_sb.note_target(t);
  endtask

  task automatic drain();
    target_ch.valid <= 1'b0;
    while (meter_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input mbph_pkg::reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    meter_sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(6))
      0:       return 32'd0;
      1:       return 32'(COEF_ONE);
      2:       return $urandom_range(131071, 65537);
      3:       return $urandom;             // upper bits must be dropped
      4:       return $urandom_range(64);
      5:       return $urandom_range(65535, 60000);
      default: return $urandom_range(65536);
    endcase
  endfunction

  function automatic logic [31:0] pick_hold();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'd65535;
      2:       return $urandom;
      default: return $urandom_range(40);
    endcase
  endfunction

  task automatic random_config();
    reg_write(mbph_pkg::REG_ATTACK, pick_coef());
    reg_write(mbph_pkg::REG_RELEASE, pick_coef());
    reg_write(mbph_pkg::REG_FALL, pick_coef());
    reg_write(mbph_pkg::REG_HOLD, pick_hold());
  endtask

  // bursts of one kind of signal: noise, steady tone, silence, negative, quiet, jittered tone
  task automatic run_random(input int n_items);
    int                     sent;
    int                     burst;
    int                     style;
    logic signed [LW-1:0]   t;
    logic signed [LW-1:0]   tone;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(60, 1);
      style = $urandom_range(5);
      tone  = ($urandom_range(3) == 0) ? {1'b0, {(LW-1){1'b1}}} : {1'b0, (LW-1)'($urandom)};
      for (int i = 0; i < burst && sent < n_items; i++) begin
        case (style)
          0:       t = LW'($urandom);
          1:       t = tone;
          2:       t = '0;
          3:       t = {1'b1, (LW-1)'($urandom)};
          4:       t = LW'($urandom_range(255));
          default: t = {1'b0, tone[LW-2:0] ^ (LW-1)'($urandom_range(15))};
        endcase
        send_target(t);
        sent++;
      end
    end
  endtask

  initial begin
    logic signed [LW-1:0] loud_then_quiet[$];
    logic signed [LW-1:0] hard_coefs[$];
    logic signed [LW-1:0] slow_coefs[$];

    rst                    <= 1'b1;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    target_ch.valid        <= 1'b0;
    target_ch.target_level <= '0;
    src_idle_pct  = 22;
    sink_idle_pct = 69;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: full scale, negative targets, equal level and peak, hold countdown
    loud_then_quiet = '{24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000000, 24'h400000,
                        24'h000001, 24'h7FFFFF, 24'h7FFFFF, 24'h000000, 24'h000000,
                        24'h000000, 24'h000000};
    foreach (loud_then_quiet[i]) send_target(loud_then_quiet[i]);
    drain();

    // coefficients above one saturate, no hold, peak falls to the level at once
    reg_write(mbph_pkg::REG_ATTACK, 32'h0001FFFF);
    reg_write(mbph_pkg::REG_RELEASE, 32'h00010005);
    reg_write(mbph_pkg::REG_FALL, 32'h0);
    reg_write(mbph_pkg::REG_HOLD, 32'h0);
    hard_coefs = '{24'h0186A0, 24'h00C350, 24'h030D40, 24'h000000, 24'h7FFFFF, 24'h000000};
    foreach (hard_coefs[i]) send_target(hard_coefs[i]);
    drain();

    // tiny attack: floored step stays zero until the gap is large; longest hold
    reg_write(mbph_pkg::REG_ATTACK, 32'd1);
    reg_write(mbph_pkg::REG_RELEASE, 32'd1);
    reg_write(mbph_pkg::REG_FALL, 32'h0000FFFF);
    reg_write(mbph_pkg::REG_HOLD, 32'h0000FFFF);
    slow_coefs = '{24'h000064, 24'h000064, 24'h7FFFFF, 24'h7FFFFF, 24'h000000, 24'h800000};
    foreach (slow_coefs[i]) send_target(slow_coefs[i]);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 22; sink_idle_pct = 69; end
        1:       begin src_idle_pct = 69; sink_idle_pct = 22; end
        default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
      endcase
      for (int seg = 0; seg < 5; seg++) begin
        random_config();
        run_random(84);
        drain();
      end
    end

    repeat (8) @(posedge clk);
    if (meter_sb.failures == 0 && meter_sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
